// ===== hw/rtl/yaz0_pkg.sv =====
// yaz0_pkg: shared types and constants for the yaz0 decompressor
// beat payload structs used by the channel interfaces and the top level
// no dependencies
package yaz0_pkg;

  // history window
  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned WIN_AW    = 12;

  // header
  localparam logic [31:0] MAGIC_YAZ0   = 32'h5961_7A30;
  localparam logic [3:0]  HDR_MAGIC_END = 4'd3;
  localparam logic [3:0]  HDR_SIZE_BEG  = 4'd4;
  localparam logic [3:0]  HDR_SIZE_END  = 4'd7;
  localparam logic [3:0]  HDR_LAST      = 4'hF;

  // group encoding
  localparam int unsigned FLAG_LIT_BIT   = 7;
  localparam logic [3:0]  GROUPS_PER_FLAG = 4'd8;
  localparam int unsigned COPY_LEN_W     = 9;
  localparam logic [COPY_LEN_W-1:0] SHORT_LEN_BIAS = 9'd2;
  localparam logic [COPY_LEN_W-1:0] LONG_LEN_BIAS  = 9'h012;

  // result beats per input byte
  localparam int unsigned BEAT_CNT_W = 6;
  localparam logic [BEAT_CNT_W-1:0] MAX_BEATS = 6'd35;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic        bad_magic;
  } out_item_t;

endpackage

// ===== hw/rtl/yaz0_chan_if.sv =====
// yaz0_chan_if: valid/ready channel carrying one payload beat
// payload type given per instance, normally a struct from yaz0_pkg
// no dependencies
interface yaz0_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/yaz0_lz_decompressor.sv =====
// yaz0_lz_decompressor: yaz0 (lz77 style) stream decompressor, one byte per input beat
// depends on yaz0_pkg and yaz0_chan_if
//
// usage
//   in_chan carries one compressed byte per beat, with stream_start high on header
//   byte 0 of a new stream (this abandons any stream in progress). out_chan carries
//   up to eight decompressed bytes per beat, earliest byte in lane 0, unused lanes zero.
//   run_last marks the final beat caused by an input byte; stream_done is set on that
//   beat once the declared size is reached. a wrong magic gives a single beat with
//   bad_magic set and byte_count 0, and the stream is ignored until the next start.
// sequence
//   header, flag and reference bytes give no beat; bad magic or empty stream gives one beat
//   literal byte: accept, window write, flush, last beat.
//   back reference of n bytes: each byte is a read of the single-port window ram followed
//   by a write, so the ram port sets the pace.
//   in_chan.ready is high only while the sequencer is idle.
// reset and stall
//   synchronous reset clears the parser, window pointer and output register; the
//   window is not swept: entries not yet written since reset read as zero via a fill
//   flag and the write pointer. when out_chan stalls, the sequencer holds at the next
//   beat hand-off; one finished beat waits in the output register and one in a
//   pending stage so run_last can be attached to the true final beat.
module yaz0_lz_decompressor #(
  parameter int unsigned BEAT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  yaz0_chan_if.sink   in_chan,
  yaz0_chan_if.source out_chan
);

  // parser phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_HEADER = 4'd1;
  localparam logic [3:0] PH_FLAG   = 4'd2;
  localparam logic [3:0] PH_LIT    = 4'd3;
  localparam logic [3:0] PH_REF1   = 4'd4;
  localparam logic [3:0] PH_REF2   = 4'd5;
  localparam logic [3:0] PH_REF3   = 4'd6;
  localparam logic [3:0] PH_DONE   = 4'd7;
  localparam logic [3:0] PH_ERROR  = 4'd8;

  // sequencer codes
  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_READ  = 3'd1;
  localparam logic [2:0] SQ_WRITE = 3'd2;
  localparam logic [2:0] SQ_FLUSH = 3'd3;
  localparam logic [2:0] SQ_LAST  = 3'd4;

  localparam logic [3:0] BEAT_FULL = 4'(BEAT_BYTES);

  // parser state
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  flags_left_r, flags_left_nxt;
  logic [7:0]  ref_first_r, ref_first_nxt;
  logic [yaz0_pkg::WIN_AW-1:0] dist_r, dist_nxt;

  // sequencer and copy state
  logic [2:0]  seq_r, seq_nxt;
  logic [yaz0_pkg::COPY_LEN_W-1:0] copy_left_r, copy_left_nxt;
  logic        lit_mode_r, lit_mode_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic        done_r, done_nxt;

  // window
  logic [7:0]  hist_mem [yaz0_pkg::WIN_DEPTH];
  logic [yaz0_pkg::WIN_AW-1:0] ptr_r, ptr_nxt;
  logic        wrapped_r, wrapped_nxt;
  logic [yaz0_pkg::WIN_AW-1:0] rd_addr;
  logic [7:0]  rdata_r;
  logic        rvalid_r;
  logic        hist_we;
  logic [7:0]  wbyte;

  // beat assembly
  logic [63:0] acc_r, acc_nxt, acc_ins;
  logic [3:0]  lanes_r, lanes_nxt;
  logic [yaz0_pkg::BEAT_CNT_W-1:0] beat_cnt_r, beat_cnt_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [63:0] pend_bytes_r, pend_bytes_nxt;
  logic [3:0]  pend_count_r, pend_count_nxt;
  logic        pend_bad_r, pend_bad_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  yaz0_pkg::out_item_t out_data_r, out_data_nxt;
  logic                slot_free;

  logic        in_fire;
  logic [7:0]  in_b;
  logic [31:0] remain_dec;
  logic        beat_full;
  logic        beat_room;
  logic [3:0]  left_dec;

  assign in_chan.ready  = (seq_r == SQ_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_b           = in_chan.data.in_byte;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign slot_free      = !out_valid_r || out_chan.ready;

  // distance field holds dist - 1
  assign rd_addr    = ptr_r - dist_r - {{(yaz0_pkg::WIN_AW-1){1'b0}}, 1'b1};
  assign wbyte      = lit_mode_r ? lit_r : (rvalid_r ? rdata_r : 8'd0);
  assign remain_dec = (remain_r != 32'd0) ? remain_r - 32'd1 : 32'd0;
  assign beat_full  = (lanes_r + 4'd1) == BEAT_FULL;
  assign beat_room  = beat_cnt_r < yaz0_pkg::MAX_BEATS;
  assign left_dec   = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;

  always_comb begin
    acc_ins = acc_r;
    acc_ins[{lanes_r[2:0], 3'b000} +: 8] = wbyte;
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    magic_nxt      = magic_r;
    remain_nxt     = remain_r;
    flags_nxt      = flags_r;
    flags_left_nxt = flags_left_r;
    ref_first_nxt  = ref_first_r;
    dist_nxt       = dist_r;
    seq_nxt        = seq_r;
    copy_left_nxt  = copy_left_r;
    lit_mode_nxt   = lit_mode_r;
    lit_nxt        = lit_r;
    done_nxt       = done_r;
    ptr_nxt        = ptr_r;
    wrapped_nxt    = wrapped_r;
    hist_we        = 1'b0;
    acc_nxt        = acc_r;
    lanes_nxt      = lanes_r;
    beat_cnt_nxt   = beat_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_count_nxt = pend_count_r;
    pend_bad_nxt   = pend_bad_r;
    out_valid_nxt  = out_chan.ready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;

    unique case (seq_r)
      SQ_IDLE: begin
        if (in_fire) begin
          // a start marker restarts the parser before the byte is used
          if (in_chan.data.stream_start) begin
            phase_nxt      = PH_HEADER;
            hdr_cnt_nxt    = 4'd0;
            magic_nxt      = 32'd0;
            remain_nxt     = 32'd0;
            flags_nxt      = 8'd0;
            flags_left_nxt = 4'd0;
          end
          unique case (phase_nxt)
            PH_HEADER: begin
              if (hdr_cnt_nxt <= yaz0_pkg::HDR_MAGIC_END) begin
                magic_nxt = {magic_nxt[23:0], in_b};
              end else if (hdr_cnt_nxt <= yaz0_pkg::HDR_SIZE_END &&
                           hdr_cnt_nxt >= yaz0_pkg::HDR_SIZE_BEG) begin
                remain_nxt = {remain_nxt[23:0], in_b};
              end
              if (hdr_cnt_nxt == yaz0_pkg::HDR_MAGIC_END &&
                  magic_nxt != yaz0_pkg::MAGIC_YAZ0) begin
                // error beat, then ignore the rest of the stream
                phase_nxt      = PH_ERROR;
                pend_valid_nxt = 1'b1;
                pend_bytes_nxt = 64'd0;
                pend_count_nxt = 4'd0;
                pend_bad_nxt   = 1'b1;
                done_nxt       = 1'b0;
                seq_nxt        = SQ_LAST;
              end else begin
                if (hdr_cnt_nxt == yaz0_pkg::HDR_LAST) begin
                  if (remain_nxt == 32'd0) begin
                    // empty stream: one done beat with no bytes
                    phase_nxt      = PH_DONE;
                    pend_valid_nxt = 1'b1;
                    pend_bytes_nxt = 64'd0;
                    pend_count_nxt = 4'd0;
                    pend_bad_nxt   = 1'b0;
                    done_nxt       = 1'b1;
                    seq_nxt        = SQ_LAST;
                  end else begin
                    phase_nxt = PH_FLAG;
                  end
                end
                hdr_cnt_nxt = hdr_cnt_nxt + 4'd1;
              end
            end
            PH_FLAG: begin
              flags_nxt      = in_b;
              flags_left_nxt = yaz0_pkg::GROUPS_PER_FLAG;
              phase_nxt      = in_b[yaz0_pkg::FLAG_LIT_BIT] ? PH_LIT : PH_REF1;
            end
            PH_LIT: begin
              lit_mode_nxt  = 1'b1;
              lit_nxt       = in_b;
              copy_left_nxt = {{(yaz0_pkg::COPY_LEN_W-1){1'b0}}, 1'b1};
              done_nxt      = 1'b0;
              seq_nxt       = SQ_WRITE;
            end
            PH_REF1: begin
              ref_first_nxt = in_b;
              phase_nxt     = PH_REF2;
            end
            PH_REF2: begin
              dist_nxt = {ref_first_r[3:0], in_b};
              if (ref_first_r[7:4] != 4'd0) begin
                // short form, length 3..17
                copy_left_nxt = {5'd0, ref_first_r[7:4]} + yaz0_pkg::SHORT_LEN_BIAS;
                lit_mode_nxt  = 1'b0;
                done_nxt      = 1'b0;
                seq_nxt       = SQ_READ;
              end else begin
                phase_nxt = PH_REF3;
              end
            end
            PH_REF3: begin
              // long form, length 18..273
              copy_left_nxt = {1'b0, in_b} + yaz0_pkg::LONG_LEN_BIAS;
              lit_mode_nxt  = 1'b0;
              done_nxt      = 1'b0;
              seq_nxt       = SQ_READ;
            end
            default: begin
            end
          endcase
        end
      end

      SQ_READ: begin
        seq_nxt = SQ_WRITE;
      end

      SQ_WRITE: begin
        // hold if this byte closes a beat and the pending beat cannot move on
        if (!(beat_full && beat_room && pend_valid_r && !slot_free)) begin
          hist_we = 1'b1;
          ptr_nxt = ptr_r + {{(yaz0_pkg::WIN_AW-1){1'b0}}, 1'b1};
          if (ptr_r == {yaz0_pkg::WIN_AW{1'b1}}) begin
            wrapped_nxt = 1'b1;
          end
          if (beat_full) begin
            lanes_nxt = 4'd0;
            acc_nxt   = 64'd0;
            if (beat_room) begin
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{out_bytes: pend_bytes_r, byte_count: pend_count_r,
                                  run_last: 1'b0, stream_done: 1'b0,
                                  bad_magic: pend_bad_r};
              end
              pend_valid_nxt = 1'b1;
              pend_bytes_nxt = acc_ins;
              pend_count_nxt = BEAT_FULL;
              pend_bad_nxt   = 1'b0;
              beat_cnt_nxt   = beat_cnt_r + 6'd1;
            end
          end else begin
            lanes_nxt = lanes_r + 4'd1;
            acc_nxt   = acc_ins;
          end
          remain_nxt    = remain_dec;
          copy_left_nxt = copy_left_r - 9'd1;
          if (remain_dec == 32'd0) begin
            // declared size reached, clip here
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
            seq_nxt   = SQ_FLUSH;
          end else if (copy_left_r == 9'd1) begin
            // advance to the next group
            flags_nxt      = {flags_r[6:0], 1'b0};
            flags_left_nxt = left_dec;
            if (left_dec == 4'd0) begin
              phase_nxt = PH_FLAG;
            end else begin
              phase_nxt = flags_r[yaz0_pkg::FLAG_LIT_BIT-1] ? PH_LIT : PH_REF1;
            end
            seq_nxt = SQ_FLUSH;
          end else begin
            seq_nxt = SQ_READ;
          end
        end
      end

      SQ_FLUSH: begin
        if (lanes_r != 4'd0 && beat_room) begin
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{out_bytes: pend_bytes_r, byte_count: pend_count_r,
                                run_last: 1'b0, stream_done: 1'b0,
                                bad_magic: pend_bad_r};
            end
            pend_valid_nxt = 1'b1;
            pend_bytes_nxt = acc_r;
            pend_count_nxt = lanes_r;
            pend_bad_nxt   = 1'b0;
            beat_cnt_nxt   = beat_cnt_r + 6'd1;
            lanes_nxt      = 4'd0;
            acc_nxt        = 64'd0;
            seq_nxt        = SQ_LAST;
          end
        end else begin
          lanes_nxt = 4'd0;
          acc_nxt   = 64'd0;
          seq_nxt   = SQ_LAST;
        end
      end

      SQ_LAST: begin
        if (slot_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{out_bytes: pend_bytes_r, byte_count: pend_count_r,
                              run_last: 1'b1, stream_done: done_r,
                              bad_magic: pend_bad_r};
          end
          pend_valid_nxt = 1'b0;
          beat_cnt_nxt   = '0;
          done_nxt       = 1'b0;
          seq_nxt        = SQ_IDLE;
        end
      end

      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  // window ram, one access per cycle
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[ptr_r] <= wbyte;
    end
    if (seq_r == SQ_READ) begin
      rdata_r  <= hist_mem[rd_addr];
      rvalid_r <= wrapped_r || (rd_addr < ptr_r);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lit_r        <= lit_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_count_r <= pend_count_nxt;
    pend_bad_r   <= pend_bad_nxt;
    out_data_r   <= out_data_nxt;
    copy_left_r  <= copy_left_nxt;
    dist_r       <= dist_nxt;
    lit_mode_r   <= lit_mode_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hdr_cnt_r    <= 4'd0;
      magic_r      <= 32'd0;
      remain_r     <= 32'd0;
      flags_r      <= 8'd0;
      flags_left_r <= 4'd0;
      ref_first_r  <= 8'd0;
      seq_r        <= SQ_IDLE;
      done_r       <= 1'b0;
      ptr_r        <= '0;
      wrapped_r    <= 1'b0;
      acc_r        <= 64'd0;
      lanes_r      <= 4'd0;
      beat_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      magic_r      <= magic_nxt;
      remain_r     <= remain_nxt;
      flags_r      <= flags_nxt;
      flags_left_r <= flags_left_nxt;
      ref_first_r  <= ref_first_nxt;
      seq_r        <= seq_nxt;
      done_r       <= done_nxt;
      ptr_r        <= ptr_nxt;
      wrapped_r    <= wrapped_nxt;
      acc_r        <= acc_nxt;
      lanes_r      <= lanes_nxt;
      beat_cnt_r   <= beat_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule
